>>> rtl/irbse_pkg.sv
package irbse_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned SymW   = 3;
  localparam int unsigned IdxW   = 3;
  localparam logic [CountW-1:0] MaxBits = CountW'(ByteW);

  localparam logic [ModeW-1:0] MODE_PD_LSB  = 3'd0;
  localparam logic [ModeW-1:0] MODE_PD_MSB  = 3'd1;
  localparam logic [ModeW-1:0] MODE_WIDE    = 3'd2;
  localparam logic [ModeW-1:0] MODE_PAIR    = 3'd3;
  localparam logic [ModeW-1:0] MODE_ZENITH  = 3'd4;
  localparam logic [ModeW-1:0] MODE_MANCH   = 3'd5;
  localparam logic [ModeW-1:0] MODE_RSVD_LO = 3'd6;
  localparam logic [ModeW-1:0] MODE_RSVD_HI = 3'd7;
  localparam logic [ModeW-1:0] CodingModeRst = MODE_PD_LSB;

  localparam logic [SymW-1:0] SYM_0 = 3'd0;
  localparam logic [SymW-1:0] SYM_1 = 3'd1;
  localparam logic [SymW-1:0] SYM_2 = 3'd2;
  localparam logic [SymW-1:0] SYM_3 = 3'd3;
  localparam logic [SymW-1:0] SYM_4 = 3'd4;

  typedef struct packed {
    logic [ByteW-1:0]  code_byte;
    logic [CountW-1:0] bit_count;
    logic              frame_final;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            byte_done;
    logic            frame_done;
  } out_item_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            two_sym;
  } sym_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

>>> rtl/ir_bit_symbol_encoder_unit.sv
// Infrared bit-to-symbol encoder.
// Input channel in_valid/in_stall/in_data carries one code byte, the number
// of its low bits to send (counts above eight act as eight) and a
// last-of-frame mark. Output channel out_valid/out_stall/out_data carries
// one timing symbol per item with last-of-byte and last-of-frame flags.
// cfg_wr_en/cfg_wr_data write the coding mode; write it only while idle.
// A byte is taken when the encoder is idle; in_stall stays high while its
// symbols are produced. One symbol goes into the output register per cycle
// while the output is not stalled. The byte is first registered, then its
// first symbol is written to the output register. A byte gives up to 16
// symbols in Zenith and Manchester modes. A byte that gives no symbols
// (zero count, unused mode) is taken and dropped at once.
// One shared bit-select unit makes every symbol, stepped by a bit index and
// a half-symbol phase. When out_stall is high with out_valid set, the output
// register holds and the sequencer waits. Reset clears the sequencer, the
// output valid and sets the coding mode to pulse distance, LSB first.
module ir_bit_symbol_encoder_unit
  import irbse_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [ModeW-1:0] cfg_wr_data
);

  state_t           state_r, state_nxt;
  logic [ModeW-1:0] mode_r;
  logic [ByteW-1:0] byte_r, byte_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [CountW-1:0] units_r, units_nxt;
  logic             phase_r, phase_nxt;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic [CountW-1:0] cnt_sat;
  logic             mode_ok;
  logic             accept;
  logic             slot_free;
  logic             emit;
  logic             last_sym;
  sym_res_t         sres;

  irbse_sym_unit u_sym (
    .mode     (mode_r),
    .code_byte(byte_r),
    .idx      (idx_r),
    .phase    (phase_r),
    .res      (sres)
  );

  assign cnt_sat   = (in_data.bit_count > MaxBits) ? MaxBits : in_data.bit_count;
  assign mode_ok   = (mode_r <= MODE_MANCH);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign emit      = (state_r == ST_RUN) && slot_free;
  assign last_sym  = (units_r == CountW'(1)) && !(sres.two_sym && !phase_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && mode_ok && (cnt_sat != '0)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (emit && last_sym) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    byte_nxt      = byte_r;
    idx_nxt       = idx_r;
    units_nxt     = units_r;
    phase_nxt     = phase_r;
    fin_nxt       = fin_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          byte_nxt  = in_data.code_byte;
          fin_nxt   = in_data.frame_final;
          phase_nxt = 1'b0;
          idx_nxt   = '0;
          units_nxt = cnt_sat;
          if (mode_r == MODE_PD_MSB) begin
            idx_nxt = IdxW'(cnt_sat - CountW'(1));
          end else if (mode_r == MODE_PAIR) begin
            units_nxt = (cnt_sat + CountW'(1)) >> 1;
          end
        end
      end
      ST_RUN: begin
        if (emit) begin
          out_valid_nxt     = 1'b1;
          out_nxt.symbol    = sres.symbol;
          out_nxt.byte_done = last_sym;
          out_nxt.frame_done = last_sym && fin_r;
          if (sres.two_sym && !phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            units_nxt = units_r - CountW'(1);
            priority if (mode_r == MODE_PD_MSB) begin
              idx_nxt = idx_r - IdxW'(1);
            end else if (mode_r == MODE_PAIR) begin
              idx_nxt = idx_r + IdxW'(2);
            end else begin
              idx_nxt = idx_r + IdxW'(1);
            end
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= CodingModeRst;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    idx_r   <= idx_nxt;
    units_r <= units_nxt;
    phase_r <= phase_nxt;
    fin_r   <= fin_nxt;
    out_r   <= out_nxt;
  end

endmodule

>>> rtl/irbse_sym_unit.sv
module irbse_sym_unit
  import irbse_pkg::*;
(
  input  logic [ModeW-1:0] mode,
  input  logic [ByteW-1:0] code_byte,
  input  logic [IdxW-1:0]  idx,
  input  logic             phase,
  output sym_res_t         res
);

  logic [ByteW-1:0] shifted;
  logic             cur_bit;
  logic [1:0]       pair;

  assign shifted = code_byte >> idx;
  assign cur_bit = shifted[0];
  assign pair    = shifted[1:0];

  always_comb begin
    res = '{symbol: SYM_1, two_sym: 1'b0};
    unique case (mode)
      MODE_PD_LSB, MODE_PD_MSB: begin
        res.symbol = cur_bit ? SYM_2 : SYM_1;
      end
      MODE_WIDE: begin
        res.symbol = cur_bit ? SYM_3 : SYM_1;
      end
      MODE_PAIR: begin
        res.symbol = SymW'(pair) + SYM_1;
      end
      MODE_ZENITH: begin
        res.two_sym = ~cur_bit;
        res.symbol  = cur_bit ? SYM_3 : (phase ? SYM_2 : SYM_1);
      end
      MODE_MANCH: begin
        res.two_sym = 1'b1;
        res.symbol  = (cur_bit ^ phase) ? SYM_0 : SYM_1;
      end
      default: begin
        res.symbol = SYM_1;
      end
    endcase
  end

endmodule

>>> rtl/irbse_checker.sv
module irbse_checker
  import irbse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_frame_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.byte_done)
    else $error("frame end without byte end");

  a_busy_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_done |-> in_stall)
    else $error("input open before byte finished");

  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.symbol <= SYM_4)
    else $error("symbol code out of range");

endmodule

bind ir_bit_symbol_encoder_unit irbse_checker u_irbse_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
